// ===== hw/rtl/bra_pkg.sv =====
`default_nettype none

package bra_pkg;

  // default geometry of the map
  localparam int BLOCK_BYTES_DEF = 64;
  localparam int MAP_BLOCKS_DEF  = 8;

  // field widths
  localparam int COUNT_W  = 13;
  localparam int UNIT_W   = 25;
  localparam int BASE_W   = 24;
  localparam int BLK_W    = 4;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic [7:0]       FULL_BYTE  = 8'hFF;
  localparam logic [BLK_W-1:0] BLOCKS_RST = 4'd8;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_RANGE     = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic {
    REG_BLOCKS = 1'b0,
    REG_BASE   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE_CHK,
    S_FREE_LEN,
    S_FREE_END,
    S_FREE,
    S_FINISH
  } state_t;

  // configuration as seen by the engine
  typedef struct packed {
    logic [BLK_W-1:0]  blocks;
    logic [BASE_W-1:0] base;
  } cfg_t;

  // number of used bits at the bottom of a byte
  function automatic logic [3:0] trail_ones(input logic [7:0] c);
    logic [3:0] n;
    logic       stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && c[i]) begin
        n = n + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

  // length of the free run that starts at bit lo
  function automatic logic [3:0] zero_run(input logic [7:0] c, input logic [3:0] lo);
    logic [3:0] n;
    logic       stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= lo) begin
        if (!stop && !c[i]) begin
          n = n + 4'd1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    return n;
  endfunction

  // bits lo .. lo+len-1
  function automatic logic [7:0] run_mask(input logic [3:0] lo, input logic [3:0] len);
    logic [7:0] m;
    logic [4:0] top;
    top = {1'b0, lo} + {1'b0, len};
    for (int i = 0; i < 8; i++) begin
      m[i] = (4'(i) >= lo) && (5'(i) < top);
    end
    return m;
  endfunction

  // bits lo .. hi inclusive
  function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) begin
      m[i] = (3'(i) >= lo) && (3'(i) <= hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bra_cfg_regs.sv =====
`default_nettype none

module bra_cfg_regs
  import bra_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blocks <= BLOCKS_RST;
      cfg.base   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_BLOCKS: cfg.blocks <= pwdata[BLK_W-1:0];
        REG_BASE:   cfg.base   <= pwdata[BASE_W-1:0];
        default:    cfg.base   <= cfg.base;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_BLOCKS: prdata = DATA_W'(cfg.blocks);
      REG_BASE:   prdata = DATA_W'(cfg.base);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bra_map_mem.sv =====
`default_nettype none

module bra_map_mem
  import bra_pkg::*;
#(
  parameter int DEPTH  = BLOCK_BYTES_DEF * MAP_BLOCKS_DEF,
  parameter int ADDR_W = 9
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data
);

  logic [7:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bra_engine.sv =====
`default_nettype none

module bra_engine
  import bra_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int MAP_BLOCKS  = MAP_BLOCKS_DEF,
  parameter int ADDR_W      = 9
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic                func,
  input  wire logic [COUNT_W-1:0]  unit_count,
  input  wire logic [UNIT_W-1:0]   start_unit,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output logic      [STATUS_W-1:0] status,
  output logic      [UNIT_W-1:0]   run_start,
  output logic      [COUNT_W-1:0]  granted_count,
  output logic                     rd_en,
  output logic      [ADDR_W-1:0]   rd_addr,
  input  wire logic [7:0]          rd_data,
  output logic                     wr_en,
  output logic      [ADDR_W-1:0]   wr_addr,
  output logic      [7:0]          wr_data
);

  localparam int MAP_BYTES = BLOCK_BYTES * MAP_BLOCKS;
  localparam int NB_W      = $clog2(MAP_BYTES + 1);
  localparam int NBIT_W    = NB_W + 3;
  localparam int BIT_W     = ADDR_W + 3;

  state_t state, state_next;

  func_t              func_q;
  logic [COUNT_W-1:0] count_q;
  logic [UNIT_W-1:0]  start_q;
  logic [NB_W-1:0]    nbytes;
  logic [NB_W-1:0]    issue_cnt;
  logic [ADDR_W-1:0]  exam_idx;
  logic               rd_pend;
  logic               found;
  logic [BIT_W-1:0]   first_idx;
  logic [COUNT_W-1:0] left;
  status_t            status_q;
  logic [COUNT_W-1:0] granted_q;
  logic [BIT_W-1:0]   pos0;
  logic [BIT_W-1:0]   last_pos;

  logic               accept;
  logic               load_rsp;
  logic [31:0]        blocks_eff;
  logic [NB_W-1:0]    nbytes_cfg;
  logic [NBIT_W-1:0]  nbits;
  logic [NB_W-1:0]    last_byte;

  // byte examine results
  logic               a_full;
  logic [3:0]         a_start;
  logic [3:0]         a_zrun;
  logic [3:0]         a_take;
  logic [COUNT_W-1:0] a_left_next;
  logic [7:0]         a_new;
  logic               a_brk;
  logic               a_exhaust;
  logic [2:0]         f_lo;
  logic [2:0]         f_hi;
  logic               f_last;

  // free range check
  logic [UNIT_W:0]    diff;
  logic               out_of_range;
  logic [NBIT_W-1:0]  avail;
  logic               short_map;

  assign accept = req_valid && !req_stall;

  // bytes in use from the block register
  assign blocks_eff = (32'(cfg.blocks) > 32'(MAP_BLOCKS)) ? 32'(MAP_BLOCKS)
                                                          : 32'(cfg.blocks);
  assign nbytes_cfg = NB_W'(blocks_eff * 32'(BLOCK_BYTES));
  assign nbits      = {nbytes, 3'b000};
  assign last_byte  = NB_W'(last_pos[BIT_W-1:3]);

  assign diff         = {1'b0, start_q} - (UNIT_W + 1)'(cfg.base);
  assign out_of_range = diff[UNIT_W] || (diff[UNIT_W-1:0] >= UNIT_W'(nbits));
  assign avail        = nbits - NBIT_W'(pos0);
  assign short_map    = 32'(count_q) > 32'(avail);

  // examine the byte that came back from the map
  always_comb begin
    a_full      = rd_data == FULL_BYTE;
    a_start     = found ? 4'd0 : trail_ones(rd_data);
    a_zrun      = zero_run(rd_data, a_start);
    a_take      = (left < COUNT_W'(a_zrun)) ? left[3:0] : a_zrun;
    a_left_next = left - COUNT_W'(a_take);
    a_new       = rd_data | run_mask(a_start, a_take);
    a_brk       = a_full ? found
                         : ((a_left_next == '0) ||
                            (({1'b0, a_start} + {1'b0, a_take}) < 5'd8));
    a_exhaust   = !rd_pend && (issue_cnt == nbytes);
    f_lo        = (exam_idx == pos0[BIT_W-1:3]) ? pos0[2:0] : 3'd0;
    f_hi        = (exam_idx == last_pos[BIT_W-1:3]) ? last_pos[2:0] : 3'd7;
    f_last      = exam_idx == last_pos[BIT_W-1:3];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (issue_cnt == NB_W'(MAP_BYTES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (func_t'(func) == FUNC_ALLOC) begin
            state_next = S_ALLOC;
          end else if (unit_count == '0) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_FREE_CHK;
          end
        end
      end
      S_ALLOC: begin
        if ((rd_pend && a_brk) || a_exhaust) begin
          state_next = S_FINISH;
        end
      end
      S_FREE_CHK: state_next = out_of_range ? S_FINISH : S_FREE_LEN;
      S_FREE_LEN: state_next = S_FREE_END;
      S_FREE_END: state_next = S_FREE;
      S_FREE: begin
        if (rd_pend && f_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    req_stall = state != S_IDLE;
    load_rsp  = (state == S_FINISH) && (!rsp_valid || !rsp_stall);
    rd_en     = 1'b0;
    rd_addr   = issue_cnt[ADDR_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = exam_idx;
    wr_data   = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = issue_cnt[ADDR_W-1:0];
      end
      S_ALLOC: begin
        rd_en   = issue_cnt < nbytes;
        wr_en   = rd_pend && !a_full;
        wr_data = a_new;
      end
      S_FREE: begin
        rd_en   = issue_cnt <= last_byte;
        wr_en   = rd_pend;
        wr_data = rd_data & ~span_mask(f_lo, f_hi);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (state == S_CLEAR || rd_en) begin
        issue_cnt <= issue_cnt + NB_W'(1);
      end else if (accept) begin
        issue_cnt <= '0;
      end else if (state == S_FREE_END) begin
        issue_cnt <= NB_W'(pos0[BIT_W-1:3]);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (rd_en) begin
      exam_idx <= issue_cnt[ADDR_W-1:0];
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          func_q    <= func_t'(func);
          count_q   <= unit_count;
          start_q   <= start_unit;
          nbytes    <= nbytes_cfg;
          left      <= unit_count;
          found     <= 1'b0;
          status_q  <= STAT_OK;
          granted_q <= '0;
        end
      end
      S_ALLOC: begin
        if (rd_pend && !a_full) begin
          left  <= a_left_next;
          found <= 1'b1;
          if (!found) begin
            first_idx <= {exam_idx, a_start[2:0]};
          end
        end
      end
      S_FREE_CHK: begin
        pos0 <= diff[BIT_W-1:0];
        if (out_of_range) begin
          status_q <= STAT_RANGE;
        end
      end
      S_FREE_LEN: begin
        if (short_map) begin
          status_q  <= STAT_RANGE;
          granted_q <= COUNT_W'(avail);
        end else begin
          granted_q <= count_q;
        end
      end
      S_FREE_END: begin
        last_pos <= pos0 + BIT_W'(granted_q) - BIT_W'(1);
      end
      default: begin
        left <= left;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      if (func_q == FUNC_ALLOC) begin
        status        <= found ? STAT_OK : STAT_NONE_FREE;
        run_start     <= found ? (UNIT_W'(first_idx) + UNIT_W'(cfg.base)) : '0;
        granted_count <= found ? (count_q - left) : '0;
      end else begin
        status        <= status_q;
        run_start     <= '0;
        granted_count <= granted_q;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_run_allocator.sv =====
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+-------------------------------------
// request   | req_valid | req_stall | func, unit_count, start_unit
// response  | rsp_valid | rsp_stall | status, run_start, granted_count
// config    | psel/penable/pwrite, pready = 1 | paddr, pwdata, prdata
//
// allocate: scans the map one byte per cycle
//   through the single read port of the map memory
// free: reads and rewrites the map bytes touched, same read port
// after reset a clearing pass writes every map byte, one per cycle
//   (BLOCK_BYTES * MAP_BLOCKS bytes, 512 by default); req_stall stays high
// the response register lets a new item in while a result waits on rsp_stall
`default_nettype none

module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int MAP_BLOCKS  = MAP_BLOCKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic                func,
  input  wire logic [COUNT_W-1:0]  unit_count,
  input  wire logic [UNIT_W-1:0]   start_unit,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output logic      [STATUS_W-1:0] status,
  output logic      [UNIT_W-1:0]   run_start,
  output logic      [COUNT_W-1:0]  granted_count,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready
);

  localparam int MAP_BYTES = BLOCK_BYTES * MAP_BLOCKS;
  localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  cfg_t              cfg;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // register file
  bra_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // usage map storage
  bra_map_mem #(
    .DEPTH  (MAP_BYTES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // scan and update sequencer
  bra_engine #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAP_BLOCKS  (MAP_BLOCKS),
    .ADDR_W      (ADDR_W)
  ) u_eng (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .func          (func),
    .unit_count    (unit_count),
    .start_unit    (start_unit),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .run_start     (run_start),
    .granted_count (granted_count),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

`ifndef NO_ASSERTIONS
  // clearing pass blocks requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> req_stall)
    else $error("request port open during clearing pass");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request port open right after an accept");

  // a failed search reports no run
  a_none_free_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STAT_NONE_FREE |-> run_start == '0 && granted_count == '0)
    else $error("none-free result carries a run");
`endif

endmodule

`default_nettype wire

// ===== dv/bitmap_run_allocator_tb.sv =====
`timescale 1ns / 1ps

module bitmap_run_allocator_tb;
  import bra_pkg::*;

  localparam int MAP_BYTES    = BLOCK_BYTES_DEF * MAP_BLOCKS_DEF;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 600;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 97;
  localparam int COUNT_MAX    = 4096;
  localparam int START_MAX    = 16781311;
  localparam int BASE_MAX     = 16777215;

  // one grant or release as the block reports it
  typedef struct packed {
    status_t             status;
    logic [UNIT_W-1:0]   run_start;
    logic [COUNT_W-1:0]  granted;
  } grant_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  // one line of the directed plan
  typedef struct packed {
    row_kind_t           kind;
    func_t               f;
    logic [COUNT_W-1:0]  cnt;
    logic [UNIT_W-1:0]   start;
    reg_idx_t            ridx;
    logic [DATA_W-1:0]   value;
    logic                typed;
    grant_t              want;
  } row_t;

  // a run handed out by an allocate, kept so it can be released later
  typedef struct packed {
    logic [UNIT_W-1:0]   start;
    logic [COUNT_W-1:0]  cnt;
  } run_t;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 req_valid  = 1'b0;
  logic                 req_stall;
  logic                 func       = 1'b0;
  logic [COUNT_W-1:0]   unit_count = '0;
  logic [UNIT_W-1:0]    start_unit = '0;
  logic                 rsp_valid;
  logic                 rsp_stall  = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [UNIT_W-1:0]    run_start;
  logic [COUNT_W-1:0]   granted_count;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [PADDR_W-1:0]   paddr      = '0;
  logic [DATA_W-1:0]    pwdata     = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // shadow copy of the map and registers
  logic [7:0]           unit_bits [MAP_BYTES];
  logic [BLK_W-1:0]     blocks_cfg;
  logic [BASE_W-1:0]    base_cfg;

  grant_t               grants_due [$];
  run_t                 live_runs [$];
  row_t                 plan [$];

  int                   fails     = 0;
  int                   cycles    = 0;
  int                   gap_pct   = 0;
  int                   stall_pct = 0;
  bit                   hold_req  = 1'b0;

  bitmap_run_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .func          (func),
    .unit_count    (unit_count),
    .start_unit    (start_unit),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .run_start     (run_start),
    .granted_count (granted_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // map bytes covered by the blocks in use, saturated at the map size
  function automatic int bytes_used();
    int b;
    b = int'(blocks_cfg);
    if (b > MAP_BLOCKS_DEF) b = MAP_BLOCKS_DEF;
    return b * BLOCK_BYTES_DEF;
  endfunction

  // apply one request to the shadow map and return what the block should answer
  function automatic grant_t run_request(input func_t f, input logic [COUNT_W-1:0] cnt,
                                         input logic [UNIT_W-1:0] start);
    grant_t     g;
    int         nbytes, nbits, left, first, n, b, rel, pos, done;
    bit         found, stop;
    logic [7:0] c;
    nbytes    = bytes_used();
    nbits     = nbytes * 8;
    g         = '0;
    g.status  = STAT_OK;
    if (f == FUNC_ALLOC) begin
      left  = int'(cnt);
      first = 0;
      found = 1'b0;
      stop  = 1'b0;
      for (n = 0; n < nbytes && !stop; n++) begin
        c = unit_bits[n];
        if (c != FULL_BYTE) begin
          b = 0;
          // first free bit of the map starts the run
          if (!found) begin
            while (b < 8 && c[b]) b++;
            first = n * 8 + b;
            found = 1'b1;
          end
          while (left != 0 && b < 8 && !c[b]) begin
            c[b] = 1'b1;
            left--;
            b++;
          end
          unit_bits[n] = c;
          stop = (left == 0) || (b < 8);
        end else begin
          stop = found;
        end
      end
      if (!found) begin
        g.status = STAT_NONE_FREE;
      end else begin
        g.run_start = UNIT_W'(first + int'(base_cfg));
        g.granted   = COUNT_W'(int'(cnt) - left);
      end
    end else if (cnt != 0) begin
      rel = int'(start) - int'(base_cfg);
      if (rel < 0 || rel >= nbits) begin
        g.status = STAT_RANGE;
      end else begin
        // clear bits until the count is done or the map ends
        pos  = rel;
        done = 0;
        while (done < int'(cnt) && pos < nbits) begin
          unit_bits[pos / 8][pos % 8] = 1'b0;
          pos++;
          done++;
        end
        if (done < int'(cnt)) g.status = STAT_RANGE;
        g.granted = COUNT_W'(done);
      end
    end
    return g;
  endfunction

  function automatic void add_req(input func_t f, input int cnt, input int start,
                                  input bit typed, input status_t st, input int rs,
                                  input int gc);
    row_t r;
    r                = '0;
    r.kind           = ROW_REQ;
    r.f              = f;
    r.cnt            = COUNT_W'(cnt);
    r.start          = UNIT_W'(start);
    r.typed          = typed;
    r.want.status    = st;
    r.want.run_start = UNIT_W'(rs);
    r.want.granted   = COUNT_W'(gc);
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(input reg_idx_t idx, input int value);
    row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.ridx  = idx;
    r.value = DATA_W'(value);
    plan.push_back(r);
  endfunction

  // drop valid and wait until every outstanding item has answered
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  // register write through setup and access cycles, only with the block idle
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BLOCKS) blocks_cfg = v[BLK_W-1:0];
    else base_cfg = v[BASE_W-1:0];
    live_runs.delete();
  endtask

  // offer one item, wait for it to be taken, then record its expected grant
  task automatic offer_request(input func_t f, input logic [COUNT_W-1:0] cnt,
                               input logic [UNIT_W-1:0] start, input logic typed,
                               input grant_t want);
    grant_t g;
    int     gap;
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 17);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    func       <= f;
    unit_count <= cnt;
    start_unit <= start;
    do @(posedge clk); while (req_stall);
    g = run_request(f, cnt, start);
    if (typed) g = want;
    grants_due.push_back(g);
    if (f == FUNC_ALLOC && g.status == STAT_OK && g.granted != 0) begin
      live_runs.push_back('{g.run_start, g.granted});
    end
  endtask

  // response side back-pressure: random bursts, plus one long hold on request
  initial begin : rsp_side
    int burst, hold_left;
    burst     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (burst > 0 && stall_pct > 0) begin
        rsp_stall <= 1'b1;
        burst--;
      end else begin
        rsp_stall <= 1'b0;
        burst = 0;
        if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
          burst = $urandom_range(1, 17);
        end
      end
    end
  end

  // compare each taken result with the oldest grant waiting
  always @(posedge clk) begin : rsp_check
    grant_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result: status %0d run_start %0d granted_count %0d",
               status, run_start, granted_count);
        fails++;
      end else begin
        want = grants_due.pop_front();
        if (status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fails++;
        end
        if (run_start != want.run_start) begin
          $error("run_start: expected %0d, got %0d", want.run_start, run_start);
          fails++;
        end
        if (granted_count != want.granted) begin
          $error("granted_count: expected %0d, got %0d", want.granted, granted_count);
          fails++;
        end
      end
    end
  end

  initial begin : main_seq
    row_t               r;
    run_t               lr;
    func_t              f;
    logic [COUNT_W-1:0] cnt;
    logic [UNIT_W-1:0]  start;
    int                 ph, i, k, sel, nbits, nitems;

    // directed plan, map all free with 8 blocks and base 0 after reset
    add_req(FUNC_ALLOC, 0, 0, 1, STAT_OK, 0, 0);
    add_req(FUNC_ALLOC, 5, 0, 1, STAT_OK, 0, 5);
    add_req(FUNC_ALLOC, COUNT_MAX, START_MAX, 1, STAT_OK, 5, 4091);
    add_req(FUNC_ALLOC, 1, 0, 1, STAT_NONE_FREE, 0, 0);
    add_req(FUNC_FREE, 0, 7, 1, STAT_OK, 0, 0);
    add_req(FUNC_FREE, 1, 4096, 1, STAT_RANGE, 0, 0);
    add_req(FUNC_FREE, 100, 4090, 1, STAT_RANGE, 0, 6);
    add_req(FUNC_FREE, 20, 10, 1, STAT_OK, 0, 20);
    add_req(FUNC_FREE, 3, 12, 1, STAT_OK, 0, 3);
    // run crosses two byte borders and stops at a used bit
    add_req(FUNC_ALLOC, 30, 0, 1, STAT_OK, 10, 20);
    add_req(FUNC_FREE, COUNT_MAX, 0, 1, STAT_OK, 0, COUNT_MAX);
    add_req(FUNC_ALLOC, 9, 0, 0, STAT_OK, 0, 0);
    add_req(FUNC_FREE, 3, 2, 0, STAT_OK, 0, 0);
    add_req(FUNC_ALLOC, 2, 0, 0, STAT_OK, 0, 0);
    // no blocks in use
    add_cfg(REG_BLOCKS, 0);
    add_req(FUNC_ALLOC, 1, 0, 1, STAT_NONE_FREE, 0, 0);
    add_req(FUNC_FREE, 5, 0, 1, STAT_RANGE, 0, 0);
    add_req(FUNC_FREE, 0, 0, 1, STAT_OK, 0, 0);
    // block count above the map size saturates
    add_cfg(REG_BLOCKS, 15);
    add_req(FUNC_FREE, 1, START_MAX, 1, STAT_RANGE, 0, 0);
    // highest base, one block
    add_cfg(REG_BASE, BASE_MAX);
    add_cfg(REG_BLOCKS, 1);
    add_req(FUNC_FREE, 4, 0, 1, STAT_RANGE, 0, 0);
    add_req(FUNC_ALLOC, 3, 0, 0, STAT_OK, 0, 0);
    add_req(FUNC_FREE, 2, BASE_MAX + 511, 1, STAT_RANGE, 0, 1);
    add_req(FUNC_ALLOC, 1, 0, 0, STAT_OK, 0, 0);
    add_req(FUNC_FREE, COUNT_MAX, START_MAX, 1, STAT_RANGE, 0, 0);
    add_cfg(REG_BASE, 0);

    for (i = 0; i < MAP_BYTES; i++) unit_bits[i] = 8'h00;
    blocks_cfg = BLOCKS_RST;
    base_cfg   = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    gap_pct   = 20;
    stall_pct = 20;
    foreach (plan[j]) begin
      r = plan[j];
      if (r.kind == ROW_CFG) write_reg(r.ridx, r.value);
      else offer_request(r.f, r.cnt, r.start, r.typed, r.want);
    end

    // random phases, each under its own register setting
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_BLOCKS, 1);
          write_reg(REG_BASE, 0);
        end
        1: begin
          write_reg(REG_BLOCKS, 2);
          write_reg(REG_BASE, $urandom_range(0, BASE_MAX));
        end
        2: begin
          write_reg(REG_BLOCKS, 8);
          write_reg(REG_BASE, BASE_MAX);
        end
        3: begin
          write_reg(REG_BLOCKS, 0);
          write_reg(REG_BASE, $urandom_range(0, BASE_MAX));
        end
        4: begin
          write_reg(REG_BLOCKS, 15);
          write_reg(REG_BASE, 0);
        end
        default: begin
          write_reg(REG_BLOCKS, $urandom_range(1, 4));
          write_reg(REG_BASE, $urandom_range(0, 1000));
        end
      endcase
      if (ph == 0 || ph == RAND_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(5, 40);
        stall_pct = $urandom_range(5, 40);
      end
      nitems = (ph == 3) ? 20 : PHASE_ITEMS;
      for (i = 0; i < nitems; i++) begin
        // long receiver hold so the block backs up into its input
        if (ph == 1 && i == 10) hold_req = 1'b1;
        // sender pause until everything has come back
        if (ph == 2 && i == 40) wait_drained();
        f = func_t'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 5) cnt = '0;
        else if (sel < 70) cnt = COUNT_W'($urandom_range(1, 16));
        else if (sel < 90) cnt = COUNT_W'($urandom_range(17, 256));
        else if (sel < 97) cnt = COUNT_W'($urandom_range(257, COUNT_MAX - 1));
        else cnt = COUNT_W'(COUNT_MAX);
        start = UNIT_W'($urandom_range(0, START_MAX));
        nbits = bytes_used() * 8;
        sel = $urandom_range(0, 99);
        if (f == FUNC_FREE) begin
          if (sel < 45 && live_runs.size() > 0) begin
            k  = $urandom_range(0, live_runs.size() - 1);
            lr = live_runs[k];
            live_runs.delete(k);
            start = lr.start;
            cnt   = lr.cnt;
          end else if (sel < 80 && nbits > 0) begin
            start = UNIT_W'(int'(base_cfg) + $urandom_range(0, nbits - 1));
          end else if (sel < 88 && base_cfg != 0) begin
            start = UNIT_W'($urandom_range(0, int'(base_cfg) - 1));
          end else if (sel < 95 && nbits > 0) begin
            // near the end of the map, often running past it
            start = UNIT_W'(int'(base_cfg) + nbits - $urandom_range(1, 16));
          end
        end
        offer_request(f, cnt, start, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && grants_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
